// ===== design/mdk_pkg.sv =====
// Package with the MD5 tables, round helpers and types shared by the key match unit.
`default_nettype none
package mdk_pkg;

  localparam int unsigned CandW = 34;
  localparam int unsigned DigestW = 64;
  localparam int unsigned Rounds = 64;

  typedef logic [CandW-1:0] cand_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5_state_t;

  typedef logic [15:0][31:0] md5_block_t;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  localparam logic [63:0][31:0] MD5_K = {
    32'heb86d391, 32'h2ad7d2bb, 32'hbd3af235, 32'hf7537e82,
    32'h4e0811a1, 32'ha3014314, 32'hfe2ce6e0, 32'h6fa87e4f,
    32'h85845dd1, 32'hffeff47d, 32'h8f0ccc92, 32'h655b59c3,
    32'hfc93a039, 32'hab9423a7, 32'h432aff97, 32'hf4292244,
    32'hc4ac5665, 32'h1fa27cf8, 32'he6db99e5, 32'hd9d4d039,
    32'h04881d05, 32'hd4ef3085, 32'heaa127fa, 32'h289b7ec6,
    32'hbebfbc70, 32'hf6bb4b60, 32'h4bdecfa9, 32'ha4beea44,
    32'hfde5380c, 32'h6d9d6122, 32'h8771f681, 32'hfffa3942,
    32'h8d2a4c8a, 32'h676f02d9, 32'hfcefa3f8, 32'ha9e3e905,
    32'h455a14ed, 32'hf4d50d87, 32'hc33707d6, 32'h21e1cde6,
    32'he7d3fbc8, 32'hd8a1e681, 32'h02441453, 32'hd62f105d,
    32'he9b6c7aa, 32'h265e5a51, 32'hc040b340, 32'hf61e2562,
    32'h49b40821, 32'ha679438e, 32'hfd987193, 32'h6b901122,
    32'h895cd7be, 32'hffff5bb1, 32'h8b44f7af, 32'h698098d8,
    32'hfd469501, 32'ha8304613, 32'h4787c62a, 32'hf57c0faf,
    32'hc1bdceee, 32'h242070db, 32'he8c7b756, 32'hd76aa478
  };

  function automatic logic [4:0] md5_shift(input logic [5:0] i);
    logic [4:0] r;
    unique case ({i[5:4], i[1:0]})
      4'h0: r = 5'd7;  4'h1: r = 5'd12; 4'h2: r = 5'd17; 4'h3: r = 5'd22;
      4'h4: r = 5'd5;  4'h5: r = 5'd9;  4'h6: r = 5'd14; 4'h7: r = 5'd20;
      4'h8: r = 5'd4;  4'h9: r = 5'd11; 4'ha: r = 5'd16; 4'hb: r = 5'd23;
      4'hc: r = 5'd6;  4'hd: r = 5'd10; 4'he: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] md5_index(input logic [5:0] i);
    logic [3:0] g;
    unique case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(5 * i + 1);
      2'd2: g = 4'(3 * i + 5);
      default: g = 4'(7 * i);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] bswap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage
`default_nettype wire

// ===== design/mdk_digits.sv =====
// Front stage: reduces the candidate and splits it into decimal digits, one per stage.
`default_nettype none
module mdk_digits
  import mdk_pkg::*;
#(
  parameter int unsigned KeyDigits = 10
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  output logic                            ready_o,
  input  wire cand_t                      cand_i,
  output logic                            valid_o,
  input  wire logic                       ready_i,
  output cand_t                           cand_o,
  output logic [KeyDigits-1:0][3:0]       digits_o
);

  localparam int unsigned NumW = CandW;

  // Each stage peels the lowest digit: q = n / 10 through reciprocal and correction.
  logic [KeyDigits:0]                    vld_q;
  cand_t [KeyDigits:0]                   cand_q;
  logic [KeyDigits:0][NumW-1:0]          num_q;
  logic [KeyDigits:0][KeyDigits-1:0][3:0] dig_q;
  logic                                  adv;

  assign adv = ready_i || !vld_q[KeyDigits];
  assign ready_o = adv;
  assign valid_o = vld_q[KeyDigits];
  assign cand_o = cand_q[KeyDigits];
  assign digits_o = dig_q[KeyDigits];

  always_comb begin
    num_q[0] = NumW'(cand_i);
    cand_q[0] = cand_i;
    vld_q[0] = valid_i;
    dig_q[0] = '0;
  end

  for (genvar s = 0; s < KeyDigits; s++) begin : g_stage
    logic [NumW-1:0]           est;
    logic [NumW-1:0]           q;
    logic [NumW-1:0]           r;
    logic [3:0]                dig;
    logic [KeyDigits-1:0][3:0] dig_d;
    always_comb begin
      est = (num_q[s] >> 1) + (num_q[s] >> 2);
      est = est + (est >> 4);
      est = est + (est >> 8);
      est = est + (est >> 16);
      est = est + (est >> 32);
      est = est >> 3;
      r = num_q[s] - ((est << 3) + (est << 1));
      if (r > NumW'(9)) begin
        q = est + NumW'(1);
        dig = 4'(r - NumW'(10));
      end else begin
        q = est;
        dig = r[3:0];
      end
      dig_d = dig_q[s];
      dig_d[s] = dig;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (adv) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        cand_q[s+1] <= cand_q[s];
        num_q[s+1] <= q;
        dig_q[s+1] <= dig_d;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/mdk_fifo.sv =====
// Short queue between the digit front end and the hash pipeline.
`default_nettype none
module mdk_fifo #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [Width-1:0] data_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output logic [Width-1:0]      data_o
);

  logic [1:0][Width-1:0] mem_q;
  logic                  wptr_q, rptr_q;
  logic [1:0]            cnt_q;
  logic                  push, pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o = mem_q[rptr_q];
  assign push = valid_i && ready_o;
  assign pop = valid_o && ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop) rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= data_i;
  end

endmodule
`default_nettype wire

// ===== design/mdk_hash.sv =====
// Back end: unrolled 64-round MD5 pipeline with the digest compare and output register.
`default_nettype none
module mdk_hash
  import mdk_pkg::*;
#(
  parameter int unsigned KeyDigits = 10
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      ready_o,
  input  wire cand_t                cand_i,
  input  wire logic [KeyDigits-1:0][3:0] digits_i,
  input  wire logic [127:0]         target_i,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output cand_t                     cand_o,
  output logic [DigestW-1:0]        digest_hi_o,
  output logic [DigestW-1:0]        digest_lo_o,
  output logic                      match_o
);

  localparam int unsigned KeyLen = KeyDigits + 1;

  logic [Rounds:0]             vld_q;
  cand_t [Rounds:0]            cand_q;
  md5_state_t [Rounds:0]       st_q;
  md5_block_t [Rounds:0]       blk_q;
  logic [127:0]                dig;
  logic                        adv;

  assign adv = ready_i || !valid_o;
  assign ready_o = adv;

  always_comb begin
    logic [63:0][7:0] bytes;
    bytes = '0;
    bytes[0] = 8'h31;
    for (int i = 0; i < KeyDigits; i++) begin
      bytes[KeyDigits - i] = {4'h3, digits_i[i]};
    end
    bytes[KeyLen] = 8'h80;
    bytes[56] = 8'(8 * KeyLen);
    bytes[57] = 8'((8 * KeyLen) >> 8);
    blk_q[0] = md5_block_t'(bytes);
    st_q[0] = '{a: InitA, b: InitB, c: InitC, d: InitD};
    vld_q[0] = valid_i;
    cand_q[0] = cand_i;
  end

  for (genvar r = 0; r < Rounds; r++) begin : g_round
    logic [31:0] f, sum, rot;
    md5_state_t  nx;
    localparam logic [5:0] R = 6'(r);
    always_comb begin
      unique case (R[5:4])
        2'd0: f = (st_q[r].b & st_q[r].c) | (~st_q[r].b & st_q[r].d);
        2'd1: f = (st_q[r].d & st_q[r].b) | (~st_q[r].d & st_q[r].c);
        2'd2: f = st_q[r].b ^ st_q[r].c ^ st_q[r].d;
        default: f = st_q[r].c ^ (st_q[r].b | ~st_q[r].d);
      endcase
      sum = st_q[r].a + f + MD5_K[r] + blk_q[r][md5_index(R)];
      rot = (sum << md5_shift(R)) | (sum >> (6'd32 - 6'(md5_shift(R))));
      nx.a = st_q[r].d;
      nx.d = st_q[r].c;
      nx.c = st_q[r].b;
      nx.b = st_q[r].b + rot;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[r+1] <= 1'b0;
      end else if (adv) begin
        vld_q[r+1] <= vld_q[r];
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_q[r+1] <= nx;
        blk_q[r+1] <= blk_q[r];
        cand_q[r+1] <= cand_q[r];
      end
    end
  end

  assign dig = {bswap32(st_q[Rounds].a + InitA), bswap32(st_q[Rounds].b + InitB),
                bswap32(st_q[Rounds].c + InitC), bswap32(st_q[Rounds].d + InitD)};

  logic        out_vld_q;
  cand_t       out_cand_q;
  logic [127:0] out_dig_q;
  logic        out_match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[Rounds];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_cand_q <= cand_q[Rounds];
      out_dig_q <= dig;
      out_match_q <= (dig == target_i);
    end
  end

  assign valid_o = out_vld_q;
  assign cand_o = out_cand_q;
  assign digest_hi_o = out_dig_q[127:64];
  assign digest_lo_o = out_dig_q[63:0];
  assign match_o = out_match_q;

endmodule
`default_nettype wire

// ===== design/md5_digit_key_match_unit.sv =====
// Top level of the MD5 digit key match unit with its configuration registers.
`default_nettype none
// One candidate request is taken every clock cycle while candidate_ready_o is
// high. A request passes a digit front end of KeyDigits stages, a two-entry queue,
// 64 unrolled MD5 round stages and one output register before its result appears.
// A stalled output holds the back end while the queue absorbs the front.
module md5_digit_key_match_unit
  import mdk_pkg::*;
#(
  parameter int unsigned KeyDigits = 10
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [63:0]       pwdata,
  output logic [63:0]            prdata,
  output logic                   pready,
  input  wire logic              candidate_valid_i,
  output logic                   candidate_ready_o,
  input  wire logic [CandW-1:0]  candidate_i,
  output logic                   result_valid_o,
  input  wire logic              result_ready_i,
  output logic [CandW-1:0]       candidate_out_o,
  output logic [DigestW-1:0]     digest_hi_o,
  output logic [DigestW-1:0]     digest_lo_o,
  output logic                   match_o
);

  localparam logic [3:0] AddrHi = 4'h0;
  localparam logic [3:0] AddrLo = 4'h8;
  localparam int unsigned QW = CandW + 4 * KeyDigits;

  logic [63:0] thi_q, tlo_q;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thi_q <= '0;
      tlo_q <= '0;
    end else if (wr) begin
      if (paddr == AddrHi) thi_q <= pwdata;
      if (paddr == AddrLo) tlo_q <= pwdata;
    end
  end

  always_comb begin
    if (paddr == AddrHi) begin
      prdata = thi_q;
    end else if (paddr == AddrLo) begin
      prdata = tlo_q;
    end else begin
      prdata = '0;
    end
  end

  logic                        fv, fr, qv, qr;
  cand_t                       fc, qc;
  logic [KeyDigits-1:0][3:0]   fd, qd;

  mdk_digits #(.KeyDigits(KeyDigits)) u_digits (
    .clk_i, .rst_ni,
    .valid_i(candidate_valid_i), .ready_o(candidate_ready_o),
    .cand_i(candidate_i),
    .valid_o(fv), .ready_i(fr), .cand_o(fc), .digits_o(fd)
  );

  mdk_fifo #(.Width(QW)) u_fifo (
    .clk_i, .rst_ni,
    .valid_i(fv), .ready_o(fr), .data_i({fc, fd}),
    .valid_o(qv), .ready_i(qr), .data_o({qc, qd})
  );

  mdk_hash #(.KeyDigits(KeyDigits)) u_hash (
    .clk_i, .rst_ni,
    .valid_i(qv), .ready_o(qr), .cand_i(qc), .digits_i(qd),
    .target_i({thi_q, tlo_q}),
    .valid_o(result_valid_o), .ready_i(result_ready_i),
    .cand_o(candidate_out_o), .digest_hi_o, .digest_lo_o, .match_o
  );

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for md5_digit_key_match_unit with its own MD5 digest predictor.
`timescale 1ns / 1ps
module tb;
  import mdk_pkg::*;

  typedef struct packed {
    logic [CandW-1:0]   cand;
    logic [DigestW-1:0] dhi;
    logic [DigestW-1:0] dlo;
    logic               hit;
  } digest_result_t;

  localparam logic [31:0] RoundConst [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };
  localparam int RotAmt [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
  localparam logic [3:0] AddrTargetHi = 4'd0;
  localparam logic [3:0] AddrTargetLo = 4'd8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic candidate_valid_i = 1'b0;
  logic candidate_ready_o;
  logic [CandW-1:0] candidate_i = '0;
  logic result_valid_o;
  logic result_ready_i = 1'b0;
  logic [CandW-1:0] candidate_out_o;
  logic [DigestW-1:0] digest_hi_o, digest_lo_o;
  logic match_o;

  logic [CandW-1:0] pending_cands [$];
  digest_result_t expected_digests [$];
  logic [63:0] tgt_hi = '0, tgt_lo = '0;
  int mismatches = 0;
  int sent = 0, received = 0, hits = 0;
  logic calm = 1'b0;

  md5_digit_key_match_unit uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] byte_swap(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  function automatic logic [127:0] digest_of(input logic [CandW-1:0] c);
    logic [63:0] n;
    logic [7:0] blk [64];
    logic [31:0] w [16];
    logic [31:0] a, b, cc, d, f, t, sum;
    int g, s;
    n = 64'(c) % 64'd10000000000;
    foreach (blk[i]) blk[i] = 8'h00;
    blk[0] = 8'h31;
    for (int i = 10; i >= 1; i--) begin
      blk[i] = 8'h30 + 8'(n % 10);
      n = n / 10;
    end
    blk[11] = 8'h80;
    blk[56] = 8'd88;
    for (int i = 0; i < 16; i++) w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    a = 32'h67452301; b = 32'hefcdab89; cc = 32'h98badcfe; d = 32'h10325476;
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = (b & cc) | (~b & d); g = i;
      end else if (i < 32) begin
        f = (d & b) | (~d & cc); g = (5 * i + 1) % 16;
      end else if (i < 48) begin
        f = b ^ cc ^ d; g = (3 * i + 5) % 16;
      end else begin
        f = cc ^ (b | ~d); g = (7 * i) % 16;
      end
      s = RotAmt[(i / 16) * 4 + i % 4];
      sum = a + f + RoundConst[i] + w[g];
      t = d; d = cc; cc = b;
      b = b + ((sum << s) | (sum >> (32 - s)));
      a = t;
    end
    return {byte_swap(a + 32'h67452301), byte_swap(b + 32'hefcdab89),
            byte_swap(cc + 32'h98badcfe), byte_swap(d + 32'h10325476)};
  endfunction

  function automatic logic [CandW-1:0] random_cand();
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(9, 0) < 8) return CandW'(r % 64'd10000000000);
    return CandW'(r);
  endfunction

  always @(posedge clk_i) begin
    digest_result_t e;
    logic [127:0] dg;
    if (candidate_valid_i && candidate_ready_o) begin
      dg = digest_of(candidate_i);
      e.cand = candidate_i;
      e.dhi = dg[127:64];
      e.dlo = dg[63:0];
      e.hit = (dg[127:64] == tgt_hi) && (dg[63:0] == tgt_lo);
      expected_digests.push_back(e);
      sent++;
    end
    if (!candidate_valid_i || candidate_ready_o) begin
      if (pending_cands.size() > 0 && (calm || $urandom_range(99, 0) >= 16)) begin
        candidate_valid_i <= 1'b1;
        candidate_i <= pending_cands.pop_front();
      end else begin
        candidate_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    digest_result_t e;
    if (result_valid_o && result_ready_i) begin
      received++;
      if (match_o) hits++;
      if (expected_digests.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result for candidate %0d", candidate_out_o);
      end else begin
        e = expected_digests.pop_front();
        if (candidate_out_o !== e.cand || digest_hi_o !== e.dhi || digest_lo_o !== e.dlo ||
            match_o !== e.hit) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %h %h %h %b, got %h %h %h %b", e.cand, e.dhi,
                     e.dlo, e.hit, candidate_out_o, digest_hi_o, digest_lo_o, match_o);
        end
      end
    end
    result_ready_i <= rst_ni && (calm || $urandom_range(99, 0) >= 16);
  end

  task automatic write_reg(input logic [3:0] addr, input logic [63:0] value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == AddrTargetHi) tgt_hi = value;
    if (addr == AddrTargetLo) tgt_lo = value;
  endtask

  task automatic drain();
    while (pending_cands.size() > 0 || candidate_valid_i || expected_digests.size() > 0)
      @(posedge clk_i);
    repeat (90) @(posedge clk_i);
  endtask

  task automatic set_target(input logic [127:0] value);
    drain();
    write_reg(AddrTargetHi, value[127:64]);
    write_reg(AddrTargetLo, value[63:0]);
  endtask

  task automatic send_random(input int count, input logic [CandW-1:0] seeded);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(49, 0) == 0) pending_cands.push_back(seeded);
      else pending_cands.push_back(random_cand());
    end
  endtask

  initial begin
    logic [127:0] goal;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    pending_cands = '{34'd0, 34'd9999999999, 34'h3ffffffff, 34'd10000000000, 34'd1,
                      34'd1234567890, 34'd42, 34'd1000000000, 34'd9999999998,
                      34'h2aaaaaaaa, 34'h155555555, 34'h200000000, 34'd4294967295};
    goal = digest_of(34'd42);
    set_target(goal);
    pending_cands = '{34'd41, 34'd42, 34'd10000000042, 34'd43};
    send_random(300, 34'd42);
    set_target({128{1'b1}});
    send_random(300, 34'd0);
    goal = digest_of(34'd9999999999);
    set_target(goal);
    calm = 1'b1;
    send_random(300, 34'd9999999999);
    drain();
    calm = 1'b0;
    set_target(digest_of(34'd0) ^ 128'h1);
    send_random(200, 34'd0);
    set_target(128'h0);
    send_random(200, 34'd0);
    drain();
    $display("Checked %0d candidates, %0d results, %0d digest hits over five target settings.",
             sent, received, hits);
    if (mismatches == 0) begin
      $display("md5_digit_key_match_unit verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("md5_digit_key_match_unit verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timed out");
    $display("md5_digit_key_match_unit verification failed");
    $finish;
  end

endmodule
